[design/mmcs_pkg.sv]
// Types and constants shared by the contrast-stretch front, queue and back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmcs_pkg;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] scaled_pixel;
        logic       last_out;
        logic [7:0] frame_min;
        logic [7:0] frame_max;
        logic       status;
    } result_t;

    // read command handed from front to back
    typedef struct packed {
        logic       err;
        logic       last;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] v;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

endpackage

`default_nettype wire

[design/mmcs_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/mmcs_front.sv]
// Front end: accepts loads and reads, keeps frame bookkeeping and the pixel store.
// Depends on mmcs_pkg and mmcs_ram.
`timescale 1ns / 1ps
`default_nettype none

module mmcs_front #(
    parameter int FRAME_DEPTH = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire mmcs_pkg::item_t    item,
    output mmcs_pkg::cmd_push_t     push
);

    import mmcs_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    logic [7:0]    min_reg, min_next;
    logic [7:0]    max_reg, max_next;
    logic          ready_reg, ready_next;
    logic          pend_reg;
    logic          pend_err_reg, pend_last_reg;
    logic [7:0]    pend_lo_reg, pend_hi_reg;

    logic [CW-1:0] cnt_eff;
    logic          room;
    logic          do_load;
    logic          do_read;
    logic          rd_err;
    logic          rd_last;
    logic [7:0]    rdata;

    assign cnt_eff = ready_reg ? '0 : count_reg;
    assign room    = cnt_eff < CW'(FRAME_DEPTH);
    assign do_load = accept && (item.op == OP_LOAD);
    assign do_read = accept && (item.op == OP_READ);
    assign rd_err  = !ready_reg || !(ridx_reg < count_reg);
    assign rd_last = (CW'(ridx_reg + 1'b1) == count_reg);

    always_comb
    begin
        count_next = count_reg;
        ridx_next  = ridx_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        ready_next = ready_reg;
        if (do_load)
        begin
            count_next = cnt_eff;
            ridx_next  = ready_reg ? '0 : ridx_reg;
            ready_next = 1'b0;
            if (room)
            begin
                count_next = CW'(cnt_eff + 1'b1);
                if (cnt_eff == '0)
                begin
                    min_next = item.pixel;
                    max_next = item.pixel;
                end
                else
                begin
                    if (item.pixel < min_reg) min_next = item.pixel;
                    if (item.pixel > max_reg) max_next = item.pixel;
                end
            end
            if (item.last)
            begin
                ready_next = 1'b1;
                ridx_next  = '0;
            end
        end
        else if (do_read && !rd_err)
        begin
            ridx_next = CW'(ridx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ridx_reg  <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            ready_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ridx_reg  <= ridx_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            ready_reg <= ready_next;
            pend_reg  <= do_read;
        end
    end

    // hold read metadata while the store lookup completes
    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            pend_err_reg  <= rd_err;
            pend_last_reg <= rd_last;
            pend_lo_reg   <= min_reg;
            pend_hi_reg   <= max_reg;
        end
    end

    mmcs_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_load && room),
        .waddr (cnt_eff[AW-1:0]),
        .wdata (item.pixel),
        .re    (do_read && !rd_err),
        .raddr (ridx_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        push.valid    = pend_reg;
        push.cmd.err  = pend_err_reg;
        push.cmd.last = pend_err_reg ? 1'b0 : pend_last_reg;
        push.cmd.lo   = pend_err_reg ? 8'd0 : pend_lo_reg;
        push.cmd.hi   = pend_err_reg ? 8'd0 : pend_hi_reg;
        push.cmd.v    = pend_err_reg ? 8'd0 : rdata;
    end

endmodule

`default_nettype wire

[design/mmcs_queue.sv]
// Short command queue between front and back.
// Depends on mmcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmcs_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mmcs_pkg::cmd_push_t       push,
    input  wire logic                      take,
    output logic                           valid,
    output mmcs_pkg::cmd_t                 head,
    output logic [mmcs_pkg::QCW-1:0]       count
);

    import mmcs_pkg::*;

    cmd_t           slot_reg [QDEPTH];
    logic [QPW-1:0] wptr_reg, rptr_reg;
    logic [QCW-1:0] count_reg;
    logic           do_take;

    assign do_take = take && (count_reg != '0);
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rptr_reg];
    assign count   = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push.valid) wptr_reg <= QPW'(wptr_reg + 1'b1);
            if (do_take)    rptr_reg <= QPW'(rptr_reg + 1'b1);
            if (push.valid && !do_take)
            begin
                count_reg <= QCW'(count_reg + 1'b1);
            end
            else if (!push.valid && do_take)
            begin
                count_reg <= QCW'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

[design/mmcs_back.sv]
// Back end: restoring divider for 255*(v-min)/(max-min) and the result register.
// Depends on mmcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmcs_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire mmcs_pkg::cmd_t     q_head,
    output logic                    q_take,
    output mmcs_pkg::result_t       result,
    output logic                    empty,
    input  wire logic               pop
);

    import mmcs_pkg::*;

    back_state_t state_reg, state_next;
    logic [2:0]  step_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  sh_reg;
    logic [7:0]  den_reg;
    logic        err_reg, last_reg;
    logic [7:0]  lo_reg, hi_reg;

    logic        trivial;
    logic [7:0]  diff;
    logic [15:0] num;
    logic [8:0]  trial;
    logic        ge;
    logic [8:0]  sub;

    assign trivial = q_head.err || (q_head.hi == q_head.lo) || (q_head.v < q_head.lo);
    assign diff    = q_head.v - q_head.lo;
    assign num     = {diff, 8'd0} - {8'd0, diff};
    assign trial   = {rem_reg, sh_reg[7]};
    assign ge      = trial >= {1'b0, den_reg};
    assign sub     = trial - {1'b0, den_reg};
    assign q_take  = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid) state_next = trivial ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == 3'd7) state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (pop) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            err_reg  <= q_head.err;
            last_reg <= q_head.last;
            lo_reg   <= q_head.lo;
            hi_reg   <= q_head.hi;
            den_reg  <= q_head.hi - q_head.lo;
            rem_reg  <= trivial ? 8'd0 : num[15:8];
            sh_reg   <= trivial ? 8'd0 : num[7:0];
            step_reg <= 3'd0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= ge ? sub[7:0] : trial[7:0];
            sh_reg   <= {sh_reg[6:0], ge};
            step_reg <= 3'(step_reg + 1'b1);
        end
    end

    assign empty               = (state_reg != ST_DONE);
    assign result.scaled_pixel = sh_reg;
    assign result.last_out     = last_reg;
    assign result.frame_min    = lo_reg;
    assign result.frame_max    = hi_reg;
    assign result.status       = err_reg;

endmodule

`default_nettype wire

[design/min_max_contrast_stretch.sv]
// Top level of the min-max contrast stretch: front, command queue and back.
// Depends on mmcs_pkg, mmcs_front, mmcs_queue and mmcs_back.
//
//   channel  direction  handshake          payload
//   item     in         push / full        item_t   (op, pixel, last)
//   result   out        empty / pop        result_t (scaled_pixel .. status)
//
// Loads go straight into the pixel store. A read passes one register in the front (store
// lookup) and one in the command queue, then eight divide steps, one quotient bit a cycle;
// the divider takes the next command only after its result has been popped.
// Flat frames and error results skip the divide steps.
// The pixel store needs no clearing: only entries of the current frame are read.
// full rises when four reads are waiting in front of the divider.
`timescale 1ns / 1ps
`default_nettype none

module min_max_contrast_stretch #(
    parameter int FRAME_DEPTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire mmcs_pkg::item_t     item,
    output logic                     empty,
    input  wire logic                pop,
    output mmcs_pkg::result_t        result
);

    import mmcs_pkg::*;

    logic           accept;
    cmd_push_t      fq_push;
    logic           q_valid;
    cmd_t           q_head;
    logic [QCW-1:0] q_count;
    logic           q_take;
    logic [QCW:0]   occupancy;

    assign occupancy = {1'b0, q_count} + {{QCW{1'b0}}, fq_push.valid};
    assign full      = occupancy >= (QCW + 1)'(QDEPTH);
    assign accept    = push && !full;

    mmcs_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (fq_push)
    );

    mmcs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .take  (q_take),
        .valid (q_valid),
        .head  (q_head),
        .count (q_count)
    );

    mmcs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_take  (q_take),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (QCW + 1)'(QDEPTH))
        else $error("command queue overflow");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status) |->
            (result.scaled_pixel == 8'd0 && result.frame_min == 8'd0 &&
             result.frame_max == 8'd0 && !result.last_out))
        else $error("error result carries data");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.status) |-> (result.frame_min <= result.frame_max))
        else $error("frame minimum above maximum");

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_min == result.frame_max) |->
            (result.scaled_pixel == 8'd0))
        else $error("flat frame gives nonzero pixel");

endmodule

`default_nettype wire
